// ----- sv/smf_pkg.sv -----
// Shared constants and types for the sliding-window median filter.
`default_nettype none

package smf_pkg;

  // Window depth and data width
  localparam int WINDOW_SIZE = 5;
  localparam int DATA_W      = 32;

  // Ring slot tag and fill count widths
  localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

  // Input operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // One cell of the sorted chain: a window sample and the ring slot it came from
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot;
  } cell_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    cell_t entry;  // current contents
    logic  le;     // valid and value <= incoming sample
    logic  ev;     // evicted entry sits at or below this cell
  } link_t;

  // Per-transaction command broadcast to every cell
  typedef struct packed {
    logic                     shift_en;  // filter sample: insert, and evict if evict_en
    logic                     fill_en;   // fill: load every cell
    logic                     evict_en;  // window full, drop the entry at wr_ptr
    logic [SLOT_W-1:0]        wr_ptr;
    logic signed [DATA_W-1:0] sample;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/sliding_median_filter_top.sv -----
// Top level of the sliding-window median filter.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  input   | in        | in_valid_i / in_stall_o   | op_i (1b), sample_i (s32)
//  output  | out       | out_valid_o / out_stall_i | median_o (s32)
//
// One transaction per cycle unless in_stall_o: the sorted cell row inserts the new sample
// and, once the window is full, drops the oldest one at the accept edge; the median is then
// picked from the row into the output register, so a result is valid once that is loaded.
// A fill transaction loads every cell and gives no result.
// rst_ni clears the cells, pointer, fill count and output flags.
// in_stall_o is high only while a result waits for the pick and the output is stalled.
`default_nettype none

module sliding_median_filter_top
  import smf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] median_o
);

  logic [SLOT_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     pend_q, pend_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] median_q;
  logic                     in_acc, filt_acc, fill_acc, pend_move;
  logic [SLOT_W-1:0]        mid_idx;
  cmd_t                     cmd;
  cell_t                    cells [WINDOW_SIZE];

  // Handshake
  assign pend_move  = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q && !pend_move;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign filt_acc   = in_acc && (op_i == OP_FILTER);
  assign fill_acc   = in_acc && (op_i == OP_FILL);

  // Command to the cell row
  always_comb begin
    cmd.shift_en = filt_acc;
    cmd.fill_en  = fill_acc;
    cmd.evict_en = (count_q == CNT_W'(WINDOW_SIZE));
    cmd.wr_ptr   = wr_ptr_q;
    cmd.sample   = sample_i;
  end

  smf_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .cells_o (cells)
  );

  // Ring pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (fill_acc) begin
      wr_ptr_d = '0;
      count_d  = CNT_W'(WINDOW_SIZE);
    end else if (filt_acc) begin
      wr_ptr_d = (wr_ptr_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (count_q != CNT_W'(WINDOW_SIZE)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Median pick: entry count/2 of the sorted row
  assign mid_idx = SLOT_W'(count_q >> 1);

  // Pending pick and output register flags
  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && pend_move) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
    if (filt_acc) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result data
  always_ff @(posedge clk_i) begin
    if (pend_q && pend_move) begin
      median_q <= cells[mid_idx].value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

`default_nettype wire

// ----- sv/smf_cell.sv -----
// One cell of the sorted window chain: insert-and-evict update from neighbor links.
`default_nettype none

module smf_cell
  import smf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] cell_idx_i,
  input  cmd_t              cmd_i,
  input  link_t             dn_i,      // neighbor holding the next smaller entry
  input  link_t             up_i,      // neighbor holding the next larger entry
  output link_t             link_o
);

  cell_t cell_q, cell_d;
  logic  own_le, own_ev, ev_at;
  cell_t l_cur, l_prev;
  logic  l_cur_le, l_prev_le;

  // Local compare and eviction match
  assign own_le = cell_q.valid && (cell_q.value <= cmd_i.sample);
  assign own_ev = cmd_i.evict_en && cell_q.valid && (cell_q.slot == cmd_i.wr_ptr);
  assign ev_at  = dn_i.ev | own_ev;

  // Entries at this place and the one below once the evicted one is squeezed out
  always_comb begin
    l_cur     = ev_at ? up_i.entry : cell_q;
    l_cur_le  = ev_at ? up_i.le    : own_le;
    l_prev    = dn_i.ev ? cell_q : dn_i.entry;
    l_prev_le = dn_i.ev ? own_le : dn_i.le;
  end

  // Next contents: load the fill sample, or keep the squeezed entry, take the new sample, or move up one
  always_comb begin
    cell_d = cell_q;
    if (cmd_i.fill_en) begin
      cell_d.valid = 1'b1;
      cell_d.value = cmd_i.sample;
      cell_d.slot  = cell_idx_i;
    end else if (cmd_i.shift_en) begin
      if (l_cur_le) begin
        cell_d = l_cur;
      end else if (l_prev_le) begin
        cell_d.valid = 1'b1;
        cell_d.value = cmd_i.sample;
        cell_d.slot  = cmd_i.wr_ptr;
      end else begin
        cell_d = l_prev;
      end
    end
  end

  // Cell register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign link_o = '{entry: cell_q, le: own_le, ev: ev_at};

endmodule

`default_nettype wire

// ----- sv/smf_chain.sv -----
// Row of sorted window cells, smallest entry in cell 0.
`default_nettype none

module smf_chain
  import smf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output cell_t cells_o [WINDOW_SIZE]
);

  link_t links [WINDOW_SIZE];
  link_t dn_edge, up_edge;

  // Virtual neighbors at both ends: minus infinity below, empty above
  always_comb begin
    dn_edge       = '0;
    dn_edge.le    = 1'b1;
    up_edge       = '0;
  end

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    link_t dn_l, up_l;

    if (i == 0) begin : g_lo
      assign dn_l = dn_edge;
    end else begin : g_mid_lo
      assign dn_l = links[i-1];
    end

    if (i == WINDOW_SIZE - 1) begin : g_hi
      assign up_l = up_edge;
    end else begin : g_mid_hi
      assign up_l = links[i+1];
    end

    smf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_W'(i)),
      .cmd_i      (cmd_i),
      .dn_i       (dn_l),
      .up_i       (up_l),
      .link_o     (links[i])
    );

    assign cells_o[i] = links[i].entry;
  end

endmodule

`default_nettype wire

// ----- sv/smf_checker.sv -----
// Port-level checks for the median filter, bound to the top level.
`default_nettype none

module smf_checker
  import smf_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     op_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] median_o
);

  logic filt_acc;
  assign filt_acc = rst_ni && in_valid_i && !in_stall_o && (op_i == OP_FILTER);

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(median_o))
    else $error("result dropped or changed while stalled");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // No result without a filter transaction just before
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(filt_acc) |=> !out_valid_o)
    else $error("result without a filter transaction");

  // A filter transaction leaves a valid output behind the pending pick and the output register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_acc |=> ##1 out_valid_o)
    else $error("no result after a filter transaction");

endmodule

bind sliding_median_filter_top smf_checker u_smf_checker (.*);

`default_nettype wire
